// ===== rtl/stb_pkg.sv =====
// shared types and constants of the software timer bank
`timescale 1ns / 1ps

package stb_pkg;

   localparam int NUM_GROUPS       = 2;
   localparam int TIMERS_PER_GROUP = 12;
   localparam int COUNT_WIDTH      = 16;

   localparam int GROUP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int TIMER_W = (TIMERS_PER_GROUP > 1) ? $clog2(TIMERS_PER_GROUP) : 1;

   localparam logic [7:0] NO_ID = 8'hFF;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_SETUP   = 3'd1,
      CMD_SET     = 3'd2,
      CMD_CHECK   = 3'd3,
      CMD_RELEASE = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        direction;
      logic [3:0]  timer_index;
      logic [15:0] count_value;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] returned_id;
      logic       expired;
   } rsp_type;

endpackage

// ===== rtl/stb_req_if.sv =====
// valid/ready channel carrying timer commands
`timescale 1ns / 1ps

interface stb_req_if
   import stb_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/stb_rsp_if.sv =====
// valid/ready channel carrying timer command results
`timescale 1ns / 1ps

interface stb_rsp_if
   import stb_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/software_timer_bank.sv =====
// bank of down-counting timers with tick, setup, set, check and release commands
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------
//   req     | in  | cmd, direction, timer_index, count_value
//   rsp     | out | accepted, returned_id, expired
//
// one command beat per cycle unless a result waits on a stalled rsp; its result beat is
// written into the output register at the same edge that takes the command
// the timer registers are updated at the same edge that takes the command
// reset (synchronous) clears all counts, expired flags and assigned marks
// while a result waits on rsp, req.ready stays high only if rsp.ready is high
`timescale 1ns / 1ps

module software_timer_bank
   import stb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   stb_req_if.sink     req,
   stb_rsp_if.source   rsp
);

   // per-timer state, one lane per slot
   logic [COUNT_WIDTH-1:0] count_ff [NUM_GROUPS][TIMERS_PER_GROUP];
   logic [COUNT_WIDTH-1:0] count_in [NUM_GROUPS][TIMERS_PER_GROUP];
   logic                   flag_ff  [NUM_GROUPS][TIMERS_PER_GROUP];
   logic                   flag_in  [NUM_GROUPS][TIMERS_PER_GROUP];
   logic                   mark_ff  [NUM_GROUPS][TIMERS_PER_GROUP];
   logic                   mark_in  [NUM_GROUPS][TIMERS_PER_GROUP];

   // output register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic                   req_beat;
   logic                   slot_ok;
   logic [GROUP_W-1:0]     group_sel;
   logic [TIMER_W-1:0]     timer_sel;
   logic                   sel_mark;
   logic                   sel_flag;
   logic [COUNT_WIDTH-1:0] load_value;

   // take a new command whenever the output register is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_beat  = req.valid && req.ready;

   // slot decode: out-of-range group or index is rejected
   assign slot_ok = ({31'd0, req.payload.direction} < 32'(NUM_GROUPS)) &&
                    ({28'd0, req.payload.timer_index} < 32'(TIMERS_PER_GROUP));
   assign group_sel  = GROUP_W'(req.payload.direction);
   assign timer_sel  = TIMER_W'(req.payload.timer_index);
   assign sel_mark   = slot_ok ? mark_ff[group_sel][timer_sel] : 1'b0;
   assign sel_flag   = slot_ok ? flag_ff[group_sel][timer_sel] : 1'b0;
   assign load_value = COUNT_WIDTH'(req.payload.count_value);

   always_comb begin
      count_in     = count_ff;
      flag_in      = flag_ff;
      mark_in      = mark_ff;
      rsp_data_in  = '{accepted: 1'b0, returned_id: NO_ID, expired: 1'b0};
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (req_beat) begin
         rsp_valid_in = 1'b1;
         unique case (cmd_type'(req.payload.cmd))
            CMD_TICK: begin
               // every running count steps down, flag rises on reaching zero
               for (int g = 0; g < NUM_GROUPS; g++) begin
                  for (int t = 0; t < TIMERS_PER_GROUP; t++) begin
                     if (count_ff[g][t] != '0) begin
                        count_in[g][t] = count_ff[g][t] - 1'b1;
                        if (count_ff[g][t] == COUNT_WIDTH'(1)) begin
                           flag_in[g][t] = 1'b1;
                        end
                     end
                  end
               end
               rsp_data_in.accepted = 1'b1;
            end
            CMD_SETUP: begin
               // claim only a free slot
               if (slot_ok && !sel_mark) begin
                  count_in[group_sel][timer_sel] = load_value;
                  flag_in[group_sel][timer_sel]  = 1'b0;
                  mark_in[group_sel][timer_sel]  = 1'b1;
                  rsp_data_in.accepted    = 1'b1;
                  rsp_data_in.returned_id = 8'(req.payload.timer_index);
               end
            end
            CMD_SET: begin
               // reload if taken, claim if free: same update either way
               if (slot_ok) begin
                  count_in[group_sel][timer_sel] = load_value;
                  flag_in[group_sel][timer_sel]  = 1'b0;
                  mark_in[group_sel][timer_sel]  = 1'b1;
                  rsp_data_in.accepted    = 1'b1;
                  rsp_data_in.returned_id = 8'(req.payload.timer_index);
               end
            end
            CMD_CHECK: begin
               if (sel_mark) begin
                  rsp_data_in.accepted = 1'b1;
                  rsp_data_in.expired  = sel_flag;
               end
            end
            CMD_RELEASE: begin
               if (sel_mark) begin
                  count_in[group_sel][timer_sel] = '0;
                  flag_in[group_sel][timer_sel]  = 1'b0;
                  mark_in[group_sel][timer_sel]  = 1'b0;
                  rsp_data_in.accepted = 1'b1;
               end
            end
            default: begin
               // unused codes leave state alone and report a reject
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            for (int t = 0; t < TIMERS_PER_GROUP; t++) begin
               count_ff[g][t] <= '0;
               flag_ff[g][t]  <= 1'b0;
               mark_ff[g][t]  <= 1'b0;
            end
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         mark_ff      <= mark_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

endmodule

// ===== verif/software_timer_bank_tb.sv =====
// self-checking testbench of the software timer bank: directed and random command beats
`timescale 1ns / 1ps

module software_timer_bank_tb;
   import stb_pkg::*;

   // command codes the block decodes as no-ops
   localparam logic [2:0] CMD_SPARE_5 = 3'd5;
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam int SLOTS         = NUM_GROUPS * TIMERS_PER_GROUP;
   localparam int DRAIN_LIMIT   = 2000;   // cycles allowed for the last results
   localparam int TAIL_CYCLES   = 4;      // quiet cycles after the last result

   logic clock;
   logic reset;

   stb_req_if req_bus ();
   stb_rsp_if rsp_bus ();

   software_timer_bank DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // shadow copy of the timer bank
   logic [COUNT_WIDTH-1:0] timer_count   [SLOTS];
   logic                   timer_expired [SLOTS];
   logic                   timer_taken   [SLOTS];

   // results still owed by the block, oldest first
   rsp_type pending_results [$];

   int  error_count;
   bit  idle_enable;    // random gaps on the command side and stalls on the result side
   int  stall_left;

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // next-state and result of one command against the shadow bank
   task automatic predict_timer_cmd(input req_type item, output rsp_type res);
      int   slot;
      logic in_range;
      in_range = (item.direction < NUM_GROUPS) && (item.timer_index < TIMERS_PER_GROUP);
      slot     = item.direction * TIMERS_PER_GROUP + item.timer_index;
      res.accepted    = 1'b0;
      res.returned_id = NO_ID;
      res.expired     = 1'b0;
      case (item.cmd)
         CMD_TICK: begin
            // every running count steps down; a count already at zero keeps its flag
            for (int k = 0; k < SLOTS; k++) begin
               if (timer_count[k] != '0) begin
                  timer_count[k] = timer_count[k] - 1'b1;
                  if (timer_count[k] == '0) timer_expired[k] = 1'b1;
               end
            end
            res.accepted = 1'b1;
         end
         CMD_SETUP, CMD_SET: begin
            // set on a free slot falls back to setup; setup on a taken slot fails
            if (in_range) begin
               if (!timer_taken[slot] || item.cmd == CMD_SET) begin
                  timer_taken[slot]   = 1'b1;
                  timer_count[slot]   = item.count_value[COUNT_WIDTH-1:0];
                  timer_expired[slot] = 1'b0;
                  res.accepted        = 1'b1;
                  res.returned_id     = {4'd0, item.timer_index};
               end
            end
         end
         CMD_CHECK: begin
            if (in_range) begin
               if (timer_taken[slot]) begin
                  res.accepted = 1'b1;
                  res.expired  = timer_expired[slot];
               end
            end
         end
         CMD_RELEASE: begin
            if (in_range) begin
               if (timer_taken[slot]) begin
                  timer_taken[slot]   = 1'b0;
                  timer_count[slot]   = '0;
                  timer_expired[slot] = 1'b0;
                  res.accepted        = 1'b1;
               end
            end
         end
         default: ;
      endcase
   endtask

   // drive one command beat; entered and left at a falling edge
   task automatic send_cmd(input logic [2:0] cmd, input logic dir, input logic [3:0] idx,
                           input logic [15:0] value);
      req_type item;
      rsp_type res;
      item.cmd         = cmd;
      item.direction   = dir;
      item.timer_index = idx;
      item.count_value = value;
      // optional gap before the beat
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= item;
      // wait for the handshake edge
      do @(posedge clock); while (!req_bus.ready);
      predict_timer_cmd(item, res);
      pending_results.push_back(res);
      @(negedge clock);
   endtask

   // sender holds off until the block owes nothing
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // result side: random stall bursts while enabled, otherwise always ready
   always @(negedge clock) begin
      if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.payload.accepted !== want.accepted)
               report_mismatch($sformatf("accepted got %b want %b",
                                         rsp_bus.payload.accepted, want.accepted));
            if (rsp_bus.payload.returned_id !== want.returned_id)
               report_mismatch($sformatf("returned_id got %0d want %0d",
                                         rsp_bus.payload.returned_id, want.returned_id));
            if (rsp_bus.payload.expired !== want.expired)
               report_mismatch($sformatf("expired got %b want %b",
                                         rsp_bus.payload.expired, want.expired));
         end
      end
   end

   // a bank straight out of reset: nothing is taken and ticks change nothing
   task automatic test_idle_bank();
      send_cmd(CMD_CHECK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_RELEASE, 1'b1, 4'(TIMERS_PER_GROUP - 1), 16'hFFFF);
      send_cmd(CMD_TICK, 1'b0, 4'd0, 16'h0000);
   endtask

   // claim, run down to zero, tick past zero, reload, release twice
   task automatic test_expiry_cycle();
      send_cmd(CMD_SETUP, 1'b0, 4'd0, 16'd2);
      send_cmd(CMD_SETUP, 1'b0, 4'd0, 16'd9);      // already taken
      send_cmd(CMD_TICK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_CHECK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_TICK, 1'b1, 4'd15, 16'hFFFF);
      send_cmd(CMD_CHECK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_TICK, 1'b0, 4'd0, 16'h0000);    // count stays at zero, flag kept
      send_cmd(CMD_CHECK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_SET, 1'b0, 4'd0, 16'hFFFF);     // reload clears the flag
      send_cmd(CMD_CHECK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_RELEASE, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_RELEASE, 1'b0, 4'd0, 16'h0000); // now free
   endtask

   // out-of-range slots and spare command codes leave the bank untouched
   task automatic test_bad_addresses();
      send_cmd(CMD_SETUP, 1'b0, 4'(TIMERS_PER_GROUP), 16'd1);
      send_cmd(CMD_SET, 1'b1, 4'd15, 16'd1);
      send_cmd(CMD_CHECK, 1'b1, 4'd14, 16'h0000);
      send_cmd(CMD_RELEASE, 1'b0, 4'd13, 16'h0000);
      send_cmd(CMD_SPARE_5, 1'b0, 4'd0, 16'h1234);
      send_cmd(CMD_SPARE_6, 1'b1, 4'd3, 16'hFFFF);
      send_cmd(CMD_SPARE_7, 1'b1, 4'd15, 16'hFFFF);
   endtask

   // set on a free slot claims it like setup
   task automatic test_set_claims_free();
      send_cmd(CMD_SET, 1'b1, 4'(TIMERS_PER_GROUP - 1), 16'd1);
      send_cmd(CMD_TICK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_CHECK, 1'b1, 4'(TIMERS_PER_GROUP - 1), 16'h0000);
   endtask

   // a zero load never raises the flag
   task automatic test_zero_load();
      send_cmd(CMD_SETUP, 1'b1, 4'd5, 16'd0);
      send_cmd(CMD_TICK, 1'b0, 4'd0, 16'h0000);
      send_cmd(CMD_CHECK, 1'b1, 4'd5, 16'h0000);
   endtask

   // weighted random commands; mostly legal slots and short counts so timers expire
   task automatic test_random_traffic(input int num_items, input bit with_idle);
      int          pick;
      logic [2:0]  cmd;
      logic [3:0]  idx;
      logic [15:0] value;
      idle_enable = with_idle;
      for (int n = 0; n < num_items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      cmd = CMD_TICK;
         else if (pick < 45) cmd = CMD_SETUP;
         else if (pick < 65) cmd = CMD_SET;
         else if (pick < 85) cmd = CMD_CHECK;
         else if (pick < 95) cmd = CMD_RELEASE;
         else                cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
         if ($urandom_range(0, 9) == 0) idx = 4'($urandom_range(TIMERS_PER_GROUP, 15));
         else                           idx = 4'($urandom_range(0, TIMERS_PER_GROUP - 1));
         pick = $urandom_range(0, 99);
         if (pick < 60)      value = 16'($urandom_range(0, 8));
         else if (pick < 85) value = 16'($urandom_range(0, 255));
         else                value = 16'($urandom);
         send_cmd(cmd, 1'($urandom), idx, value);
      end
   endtask

   // one pause in mid-traffic until the block has answered everything
   task automatic test_drain_pause();
      test_random_traffic(100, 1'b1);
      wait_results_drained();
      test_random_traffic(100, 1'b1);
   endtask

   initial begin
      int waited;
      error_count     = 0;
      idle_enable     = 1'b0;
      stall_left      = 0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
         timer_count[k]   = '0;
         timer_expired[k] = 1'b0;
         timer_taken[k]   = 1'b0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part with the result side always ready
      test_idle_bank();
      test_expiry_cycle();
      test_bad_addresses();
      test_set_claims_free();
      test_zero_load();

      // random part: idling first, a full drain in between, no idling at the end
      test_random_traffic(500, 1'b1);
      test_drain_pause();
      test_random_traffic(300, 1'b0);
      req_bus.valid <= 1'b0;

      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
